// File: design/smloc_pkg.sv
// Shared types and constants for the substring match locator.
`timescale 1ns / 1ps

package smloc_pkg;

  localparam int PatternMax = 16;
  localparam int LenW       = $clog2(PatternMax);     // holds length minus one
  localparam int FillW      = $clog2(PatternMax + 1);
  localparam int LineW      = 32;
  localparam int ColW       = 16;
  localparam int CfgW       = 64;
  localparam int CfgIdxW    = 2;
  localparam int PlenW      = 5;

  localparam logic [7:0] NewlineByte = 8'h0A;

  localparam logic [CfgIdxW-1:0] CfgPatternLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternLow    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatternHigh   = 2'd2;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_EOF   = 1'b1
  } result_kind_t;

  // one window slot: a text byte and where it sits in the file
  typedef struct packed {
    logic [7:0]       data;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
  } entry_t;

  typedef entry_t [PatternMax-1:0] window_t;

  typedef struct packed {
    logic             hit;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
  } match_t;

endpackage

// File: design/smloc_window.sv
// Shift line of recent bytes with their line and column tags.
`timescale 1ns / 1ps

module smloc_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_accept,
  input  logic                          end_accept,
  input  logic [7:0]                    data_byte,
  output smloc_pkg::window_t            view,
  output logic [smloc_pkg::FillW-1:0]   fill_next
);

  smloc_pkg::entry_t                 stored [smloc_pkg::PatternMax-1];
  logic [smloc_pkg::FillW-1:0]       fill;
  logic [smloc_pkg::LineW-1:0]       line;
  logic [smloc_pkg::ColW-1:0]        col;
  logic                              prev_nl;
  logic [smloc_pkg::LineW-1:0]       line_cur;
  logic [smloc_pkg::ColW-1:0]        col_cur;

  // tags for the incoming byte
  always_comb begin
    line_cur = line;
    col_cur  = col;
    if (prev_nl) begin
      if (line != {smloc_pkg::LineW{1'b1}}) begin
        line_cur = line + 1'b1;
      end
      col_cur = '0;
    end
  end

  // window as it stands once the incoming byte is shifted in; slot 0 is newest
  always_comb begin
    view[0].data = data_byte;
    view[0].line = line_cur;
    view[0].col  = col_cur;
    for (int k = 1; k < smloc_pkg::PatternMax; k++) begin
      view[k] = stored[k-1];
    end
  end

  assign fill_next = (fill == smloc_pkg::FillW'(smloc_pkg::PatternMax)) ? fill : fill + 1'b1;

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      for (int k = 0; k < smloc_pkg::PatternMax - 1; k++) begin
        stored[k] <= view[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || end_accept) begin
      fill    <= '0;
      line    <= smloc_pkg::LineW'(1);
      col     <= '0;
      prev_nl <= 1'b0;
    end else if (byte_accept) begin
      fill    <= fill_next;
      line    <= line_cur;
      col     <= (col_cur == {smloc_pkg::ColW{1'b1}}) ? col_cur : col_cur + 1'b1;
      prev_nl <= (data_byte == smloc_pkg::NewlineByte);
    end
  end

endmodule

// File: design/smloc_matcher.sv
// Parallel compare of the window against the pattern.
`timescale 1ns / 1ps

module smloc_matcher (
  input  smloc_pkg::window_t               view,
  input  logic [smloc_pkg::FillW-1:0]      fill_next,
  input  logic [smloc_pkg::LenW-1:0]       len_m1,
  input  logic [smloc_pkg::PatternMax-1:0][7:0] pattern,
  output smloc_pkg::match_t                result
);

  logic [smloc_pkg::PatternMax-1:0] slot_ok;
  logic [smloc_pkg::LenW-1:0]       pidx;

  // window slot k holds the byte that must equal pattern[len-1-k]
  always_comb begin
    slot_ok = '1;
    pidx    = '0;
    for (int k = 0; k < smloc_pkg::PatternMax; k++) begin
      pidx = len_m1 - smloc_pkg::LenW'(k);
      if (smloc_pkg::LenW'(k) <= len_m1) begin
        slot_ok[k] = (pattern[pidx] == view[k].data);
      end
    end
  end

  assign result.hit  = (&slot_ok) && (fill_next > smloc_pkg::FillW'(len_m1));
  assign result.line = view[len_m1].line;
  assign result.col  = view[len_m1].col;

endmodule

// File: design/substring_match_locator.sv
// Top level: configuration, byte window, matcher and result register.
`timescale 1ns / 1ps

// Substring match locator.
// Input stream: s_tdata[7:0] carries one text byte per word; s_tlast marks
// end of file (no byte carried). Every byte value is data.
// Output stream: m_tuser is the result kind (0 match, 1 end status);
// m_tdata holds start line, start column and, at end status, any_found.
// A match word leaves in the cycle after the word that completes the pattern;
// an end word gives its status in the cycle after it and clears line, column
// and window for the next file. Bytes that complete no match give no word.
// Throughput is one word per cycle unless the receiver stalls: the whole
// window compare sits between the input handshake and the result register.
// The result register frees when m_tready is high, so s_tready follows
// m_tready while a result waits; a stalled receiver stalls the input.
// Reset: pattern length 1, pattern bytes zero, line 1, column 0, no result.
// cfg_we writes register cfg_index (0 length, 1 bytes 0-7, 2 bytes 8-15);
// write only while the stream is idle. Index 3 is ignored.
module substring_match_locator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_marker
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [31:0] match_line, [47:32] match_column,
                                 // [48] any_found, [55:49] zero
  output logic        m_tuser,   // result_kind
  input  logic        cfg_we,
  input  logic [smloc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [smloc_pkg::CfgW-1:0]    cfg_data
);

  logic [smloc_pkg::PlenW-1:0]             pattern_length;
  logic [smloc_pkg::CfgW-1:0]              pattern_low;
  logic [smloc_pkg::CfgW-1:0]              pattern_high;
  logic [smloc_pkg::LenW-1:0]              len_m1;
  logic                                    accept;
  logic                                    byte_accept;
  logic                                    end_accept;
  logic                                    found;
  smloc_pkg::window_t                      view;
  logic [smloc_pkg::FillW-1:0]             fill_next;
  smloc_pkg::match_t                       match;
  logic [smloc_pkg::LineW-1:0]             out_line;
  logic [smloc_pkg::ColW-1:0]              out_col;
  logic                                    out_any;
  smloc_pkg::result_kind_t                 out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= smloc_pkg::PlenW'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        smloc_pkg::CfgPatternLength: pattern_length <= cfg_data[smloc_pkg::PlenW-1:0];
        smloc_pkg::CfgPatternLow:    pattern_low    <= cfg_data;
        smloc_pkg::CfgPatternHigh:   pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // length 0 acts as 1, anything past the window as the full window
  always_comb begin
    if (pattern_length == '0) begin
      len_m1 = '0;
    end else if (pattern_length > smloc_pkg::PlenW'(smloc_pkg::PatternMax)) begin
      len_m1 = smloc_pkg::LenW'(smloc_pkg::PatternMax - 1);
    end else begin
      len_m1 = smloc_pkg::LenW'(pattern_length - 1'b1);
    end
  end

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign byte_accept = accept && !s_tlast;
  assign end_accept  = accept && s_tlast;

  smloc_window u_window (
    .clk         (clk),
    .rst         (rst),
    .byte_accept (byte_accept),
    .end_accept  (end_accept),
    .data_byte   (s_tdata),
    .view        (view),
    .fill_next   (fill_next)
  );

  smloc_matcher u_matcher (
    .view      (view),
    .fill_next (fill_next),
    .len_m1    (len_m1),
    .pattern   ({pattern_high, pattern_low}),
    .result    (match)
  );

  always_ff @(posedge clk) begin
    if (rst || end_accept) begin
      found <= 1'b0;
    end else if (byte_accept && match.hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= s_tlast || match.hit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_accept) begin
      out_kind <= smloc_pkg::KIND_EOF;
      out_line <= '0;
      out_col  <= '0;
      out_any  <= found;
    end else if (byte_accept && match.hit) begin
      out_kind <= smloc_pkg::KIND_MATCH;
      out_line <= match.line;
      out_col  <= match.col;
      out_any  <= 1'b0;
    end
  end

  assign m_tdata = {7'b0, out_any, out_col, out_line};
  assign m_tuser = out_kind;

endmodule
